[hw/rtl/osot_pkg.sv]
// Shared constants and helper functions for the oriented square overlap test.
package osot_pkg;

    localparam int PPM_W     = 10;
    localparam int COORD_W   = 16;
    localparam int HALF_W    = 13;
    localparam int ANG_W     = 16;
    localparam int ANG_FRAC  = 24;
    localparam int TRIG_FRAC = 30;
    localparam int MAX_ITER  = 24;

    // CORDIC datapath widths
    localparam int ZW = 28;
    localparam int XW = 34;

    localparam logic [PPM_W-1:0] PPM_RESET = PPM_W'(50);

    localparam logic signed [ZW-1:0] ANG_HALF_PI = ZW'(26353589);
    localparam logic signed [ZW-1:0] ANG_PI      = ZW'(52707179);
    localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

    // arctangent of 2^-i in Q24; beyond step 7 it is taken as 2^(24-i)
    function automatic logic signed [ZW-1:0] atan_val(input int i);
        logic signed [ZW-1:0] r;
        r = '0;
        case (i)
            0: r = ZW'(13176795);
            1: r = ZW'(7778716);
            2: r = ZW'(4110060);
            3: r = ZW'(2086331);
            4: r = ZW'(1047214);
            5: r = ZW'(524117);
            6: r = ZW'(262123);
            7: r = ZW'(131069);
            default: r[ANG_FRAC - i] = 1'b1;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/osot_corners.sv]
// One square: angle folding, pipelined CORDIC and rounding of the four pixel corners.
module osot_corners #(
    parameter int FRAC = 8,
    parameter int ITER = 16,
    parameter int PW   = 19
) (
    input  logic                          i_clk,
    input  logic [osot_pkg::PPM_W-1:0]    i_ppm,
    input  logic signed [osot_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [osot_pkg::COORD_W-1:0] i_center_y,
    input  logic [osot_pkg::HALF_W-1:0]   i_half_side,
    input  logic signed [osot_pkg::ANG_W-1:0]   i_angle,
    output logic signed [PW-1:0]          o_px [4],
    output logic signed [PW-1:0]          o_py [4]
);
    import osot_pkg::*;

    localparam int HPW = HALF_W + PPM_W;           // h * ppm, unsigned
    localparam int CPW = COORD_W + PPM_W + 1;      // center * ppm, signed
    localparam int MW  = HPW + 1 + XW;             // h * ppm * trig
    localparam int RW  = MW + 1;
    localparam int SH  = FRAC + TRIG_FRAC;
    localparam logic signed [RW-1:0] R_HALF = RW'(1) <<< (SH - 1);
    localparam logic signed [CPW-1:0] C_HALF = CPW'(1) <<< (FRAC - 1);

    // front stage
    logic signed [ZW-1:0]  r_z, n_z;
    logic                  r_neg, n_neg;
    logic [HPW-1:0]        r_hp;
    logic signed [CPW-1:0] r_cpx, r_cpy;
    logic signed [ZW-1:0]  z_ext;

    always_comb begin
        z_ext = {i_angle[ANG_W-1], i_angle, 11'b0};
        n_z   = z_ext;
        n_neg = 1'b0;
        if (z_ext > ANG_HALF_PI) begin
            n_z   = z_ext - ANG_PI;
            n_neg = 1'b1;
        end else if (z_ext < -ANG_HALF_PI) begin
            n_z   = z_ext + ANG_PI;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z   <= n_z;
        r_neg <= n_neg;
        r_hp  <= HPW'(i_half_side) * HPW'(i_ppm);
        r_cpx <= CPW'(i_center_x) * signed'(CPW'({1'b0, i_ppm}));
        r_cpy <= CPW'(i_center_y) * signed'(CPW'({1'b0, i_ppm}));
    end

    // CORDIC rotation stages, side data travels alongside
    logic signed [XW-1:0]  r_x   [1:ITER];
    logic signed [XW-1:0]  r_y   [1:ITER];
    logic signed [ZW-1:0]  r_zs  [1:ITER];
    logic                  r_ng  [1:ITER];
    logic [HPW-1:0]        r_dhp [1:ITER];
    logic signed [CPW-1:0] r_dcx [1:ITER];
    logic signed [CPW-1:0] r_dcy [1:ITER];

    for (genvar i = 0; i < ITER; i++) begin : g_stage
        logic signed [XW-1:0]  x_in, y_in;
        logic signed [ZW-1:0]  z_in;
        logic                  ng_in;
        logic [HPW-1:0]        hp_in;
        logic signed [CPW-1:0] cx_in, cy_in;
        localparam logic signed [ZW-1:0] A = atan_val(i);

        if (i == 0) begin : g_first
            assign x_in  = CORDIC_GAIN;
            assign y_in  = '0;
            assign z_in  = r_z;
            assign ng_in = r_neg;
            assign hp_in = r_hp;
            assign cx_in = r_cpx;
            assign cy_in = r_cpy;
        end else begin : g_next
            assign x_in  = r_x[i];
            assign y_in  = r_y[i];
            assign z_in  = r_zs[i];
            assign ng_in = r_ng[i];
            assign hp_in = r_dhp[i];
            assign cx_in = r_dcx[i];
            assign cy_in = r_dcy[i];
        end

        always_ff @(posedge i_clk) begin
            if (!z_in[ZW-1]) begin
                r_x[i+1]  <= x_in - (y_in >>> i);
                r_y[i+1]  <= y_in + (x_in >>> i);
                r_zs[i+1] <= z_in - A;
            end else begin
                r_x[i+1]  <= x_in + (y_in >>> i);
                r_y[i+1]  <= y_in - (x_in >>> i);
                r_zs[i+1] <= z_in + A;
            end
            r_ng[i+1]  <= ng_in;
            r_dhp[i+1] <= hp_in;
            r_dcx[i+1] <= cx_in;
            r_dcy[i+1] <= cy_in;
        end
    end

    // offsets and rounded centres
    logic signed [XW-1:0] cos_v, sin_v;
    logic signed [MW-1:0] r_hc, r_hs;
    logic signed [PW-1:0] r_cx1, r_cy1, r_cx2, r_cy2, r_cx3, r_cy3;
    logic signed [RW-1:0] r_p, r_m;
    logic signed [PW-1:0] r_pr, r_mr;
    logic signed [CPW-1:0] cxs, cys;
    logic signed [RW-1:0]  ps, ms;

    assign cos_v = r_ng[ITER] ? -r_x[ITER] : r_x[ITER];
    assign sin_v = r_ng[ITER] ? -r_y[ITER] : r_y[ITER];

    // half away from zero: add half, or half less one for negatives, then floor
    assign cxs = r_dcx[ITER] + (r_dcx[ITER][CPW-1] ? C_HALF - CPW'(1) : C_HALF);
    assign cys = r_dcy[ITER] + (r_dcy[ITER][CPW-1] ? C_HALF - CPW'(1) : C_HALF);
    assign ps  = r_p + (r_p[RW-1] ? R_HALF - RW'(1) : R_HALF);
    assign ms  = r_m + (r_m[RW-1] ? R_HALF - RW'(1) : R_HALF);

    always_ff @(posedge i_clk) begin
        r_hc  <= MW'(signed'({1'b0, r_dhp[ITER]})) * MW'(cos_v);
        r_hs  <= MW'(signed'({1'b0, r_dhp[ITER]})) * MW'(sin_v);
        r_cx1 <= PW'(cxs >>> FRAC);
        r_cy1 <= PW'(cys >>> FRAC);
        r_p   <= RW'(r_hc) + RW'(r_hs);
        r_m   <= RW'(r_hc) - RW'(r_hs);
        r_cx2 <= r_cx1;
        r_cy2 <= r_cy1;
        r_pr  <= PW'(ps >>> SH);
        r_mr  <= PW'(ms >>> SH);
        r_cx3 <= r_cx2;
        r_cy3 <= r_cy2;
        o_px[0] <= r_cx3 - r_mr;
        o_py[0] <= r_cy3 - r_pr;
        o_px[1] <= r_cx3 + r_pr;
        o_py[1] <= r_cy3 - r_mr;
        o_px[2] <= r_cx3 + r_mr;
        o_py[2] <= r_cy3 + r_pr;
        o_px[3] <= r_cx3 - r_pr;
        o_py[3] <= r_cy3 + r_mr;
    end

endmodule

[hw/rtl/osot_axis_lane.sv]
// One test axis: projects all eight corners, finds both intervals, flags separation.
module osot_axis_lane #(
    parameter int PW = 19
) (
    input  logic                  i_clk,
    input  logic signed [PW:0]    i_axis_x,
    input  logic signed [PW:0]    i_axis_y,
    input  logic signed [PW-1:0]  i_ax [4],
    input  logic signed [PW-1:0]  i_ay [4],
    input  logic signed [PW-1:0]  i_bx [4],
    input  logic signed [PW-1:0]  i_by [4],
    output logic                  o_sep
);
    localparam int QW = 2 * PW + 2;

    logic signed [QW-1:0] r_pa [4];
    logic signed [QW-1:0] r_pb [4];
    logic signed [QW-1:0] r_lo1, r_hi1, r_lo2, r_hi2;

    function automatic logic signed [QW-1:0] smin(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        return (b < a) ? b : a;
    endfunction

    function automatic logic signed [QW-1:0] smax(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        return (b > a) ? b : a;
    endfunction

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_pa[k] <= QW'(i_ax[k]) * QW'(i_axis_x) + QW'(i_ay[k]) * QW'(i_axis_y);
            r_pb[k] <= QW'(i_bx[k]) * QW'(i_axis_x) + QW'(i_by[k]) * QW'(i_axis_y);
        end
        r_lo1 <= smin(smin(r_pa[0], r_pa[1]), smin(r_pa[2], r_pa[3]));
        r_hi1 <= smax(smax(r_pa[0], r_pa[1]), smax(r_pa[2], r_pa[3]));
        r_lo2 <= smin(smin(r_pb[0], r_pb[1]), smin(r_pb[2], r_pb[3]));
        r_hi2 <= smax(smax(r_pb[0], r_pb[1]), smax(r_pb[2], r_pb[3]));
        // strict: touching intervals do not separate
        o_sep <= (r_hi1 < r_lo2) || (r_lo1 > r_hi2);
    end

endmodule

[hw/rtl/oriented_square_overlap_test_unit.sv]
// Top level of the oriented square overlap test: two corner units, four axis lanes, merge.
//
// Usage:
//   Drive the eight square fields and raise start; a transaction is taken at
//   every rising edge with start high and busy low. busy is always low,
//   so a new pair may be presented on every cycle.
//   o_valid pulses for one cycle with o_overlapping once the transaction has
//   passed the front stage, a register for each CORDIC step, four offset and
//   corner stages, the axis stage, three projection and interval stages and
//   the merge register.
//   Throughput is one pair per cycle; every stage is fully pipelined.
//   Results come out in order; the receiver cannot stall, so nothing waits.
//   i_cfg_we with i_cfg_data writes pixels_per_meter; write it only while no
//   transaction is in flight.
//   Reset (synchronous, i_rst_n low) clears the result strobes in flight and
//   sets pixels_per_meter to 50.
module oriented_square_overlap_test_unit #(
    parameter int COORD_FRAC_BITS   = 8,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_we,
    input  logic [osot_pkg::PPM_W-1:0]          i_cfg_data,
    input  logic signed [osot_pkg::COORD_W-1:0] i_first_center_x,
    input  logic signed [osot_pkg::COORD_W-1:0] i_first_center_y,
    input  logic [osot_pkg::HALF_W-1:0]         i_first_half_side,
    input  logic signed [osot_pkg::ANG_W-1:0]   i_first_angle,
    input  logic signed [osot_pkg::COORD_W-1:0] i_second_center_x,
    input  logic signed [osot_pkg::COORD_W-1:0] i_second_center_y,
    input  logic [osot_pkg::HALF_W-1:0]         i_second_half_side,
    input  logic signed [osot_pkg::ANG_W-1:0]   i_second_angle,
    output logic                                o_valid,
    output logic                                o_overlapping
);
    import osot_pkg::*;

    localparam int ITER = (CORDIC_ITERATIONS > MAX_ITER) ? MAX_ITER : CORDIC_ITERATIONS;
    localparam int PW   = 27 - COORD_FRAC_BITS;
    localparam int LAT  = ITER + 10;

    logic [PPM_W-1:0] r_ppm;
    logic [LAT-1:0]   r_vld;

    logic signed [PW-1:0] ax [4], ay [4], bx [4], by [4];
    logic signed [PW-1:0] r_ax [4], r_ay [4], r_bx [4], r_by [4];
    logic signed [PW:0]   r_axis_x [4], r_axis_y [4];
    logic [3:0]           sep;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppm <= PPM_RESET;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ppm <= i_cfg_data;
            end
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    assign o_valid = r_vld[LAT-1];

    osot_corners #(.FRAC(COORD_FRAC_BITS), .ITER(ITER), .PW(PW)) u_first (
        .i_clk       (i_clk),
        .i_ppm       (r_ppm),
        .i_center_x  (i_first_center_x),
        .i_center_y  (i_first_center_y),
        .i_half_side (i_first_half_side),
        .i_angle     (i_first_angle),
        .o_px        (ax),
        .o_py        (ay)
    );

    osot_corners #(.FRAC(COORD_FRAC_BITS), .ITER(ITER), .PW(PW)) u_second (
        .i_clk       (i_clk),
        .i_ppm       (r_ppm),
        .i_center_x  (i_second_center_x),
        .i_center_y  (i_second_center_y),
        .i_half_side (i_second_half_side),
        .i_angle     (i_second_angle),
        .o_px        (bx),
        .o_py        (by)
    );

    // edge normals, unnormalised
    always_ff @(posedge i_clk) begin
        r_axis_x[0] <= (PW+1)'(ay[0]) - (PW+1)'(ay[1]);
        r_axis_y[0] <= (PW+1)'(ax[1]) - (PW+1)'(ax[0]);
        r_axis_x[1] <= (PW+1)'(ay[1]) - (PW+1)'(ay[2]);
        r_axis_y[1] <= (PW+1)'(ax[2]) - (PW+1)'(ax[1]);
        r_axis_x[2] <= (PW+1)'(by[0]) - (PW+1)'(by[1]);
        r_axis_y[2] <= (PW+1)'(bx[1]) - (PW+1)'(bx[0]);
        r_axis_x[3] <= (PW+1)'(by[1]) - (PW+1)'(by[2]);
        r_axis_y[3] <= (PW+1)'(bx[2]) - (PW+1)'(bx[1]);
        r_ax <= ax;
        r_ay <= ay;
        r_bx <= bx;
        r_by <= by;
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        osot_axis_lane #(.PW(PW)) u_lane (
            .i_clk    (i_clk),
            .i_axis_x (r_axis_x[k]),
            .i_axis_y (r_axis_y[k]),
            .i_ax     (r_ax),
            .i_ay     (r_ay),
            .i_bx     (r_bx),
            .i_by     (r_by),
            .o_sep    (sep[k])
        );
    end

    always_ff @(posedge i_clk) begin
        o_overlapping <= ~|sep;
    end

`ifndef SYNTHESIS
    a_strobe_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result strobe without a transaction");
    a_never_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_ppm == $past(i_cfg_data))
        else $error("scale register not written");
`endif

endmodule

[bench/tb_oriented_square_overlap_test_unit.sv]
// Testbench for the oriented square overlap test unit: random and directed square pairs.
`timescale 1ns / 1ps

module tb_oriented_square_overlap_test_unit;

    import osot_pkg::*;

    localparam int FRAC  = 8;
    localparam int ITERS = 16;
    localparam int LIMIT = 400000;

    typedef struct {
        logic signed [COORD_W-1:0] ax, ay;
        logic [HALF_W-1:0]         ah;
        logic signed [ANG_W-1:0]   aa;
        logic signed [COORD_W-1:0] bx, by;
        logic [HALF_W-1:0]         bh;
        logic signed [ANG_W-1:0]   ba;
    } t_square_pair;

    // expected overlap flags, oldest first; own copy of the scale register
    class t_overlap_scoreboard;
        bit          pending[$];
        logic [PPM_W-1:0] scale;
        int          errors;

        function void set_scale(logic [PPM_W-1:0] v);
            scale = v;
        endfunction

        function longint round_away(longint v, int s);
            longint half;
            half = longint'(1) <<< (s - 1);
            if (v >= 0) return (v + half) >>> s;
            return -((-v + half) >>> s);
        endfunction

        function void sine_cosine(logic signed [ANG_W-1:0] ang, output longint c,
                                  output longint s);
            longint atans[8] = '{13176795, 7778716, 4110060, 2086331,
                                 1047214, 524117, 262123, 131069};
            longint z, x, y, step, xs, ys;
            bit     flip;
            z = longint'(ang) * 2048;
            x = 652032874;
            y = 0;
            flip = 0;
            if (z > 26353589) begin
                z -= 52707179; flip = 1;
            end else if (z < -26353589) begin
                z += 52707179; flip = 1;
            end
            for (int i = 0; i < ITERS; i++) begin
                step = (i < 8) ? atans[i] : (longint'(1) <<< (24 - i));
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys; y = y + xs; z -= step;
                end else begin
                    x = x + ys; y = y - xs; z += step;
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void corners_of(logic signed [COORD_W-1:0] cxi, logic signed [COORD_W-1:0] cyi,
                                 logic [HALF_W-1:0] h, logic signed [ANG_W-1:0] ang,
                                 output longint px[4], output longint py[4]);
            int     sx[4] = '{-1, 1, 1, -1};
            int     sy[4] = '{-1, -1, 1, 1};
            longint k, cx, cy, c, s, hc, hs;
            k  = longint'(scale);
            cx = round_away(longint'(cxi) * k, FRAC);
            cy = round_away(longint'(cyi) * k, FRAC);
            sine_cosine(ang, c, s);
            hc = longint'(h) * c * k;
            hs = longint'(h) * s * k;
            for (int i = 0; i < 4; i++) begin
                px[i] = cx + round_away(sx[i] * hc - sy[i] * hs, FRAC + 30);
                py[i] = cy + round_away(sx[i] * hs + sy[i] * hc, FRAC + 30);
            end
        endfunction

        function bit squares_overlap(t_square_pair p);
            longint ax[4], ay[4], bx[4], by[4], nx[4], ny[4];
            longint lo1, hi1, lo2, hi2, v;
            corners_of(p.ax, p.ay, p.ah, p.aa, ax, ay);
            corners_of(p.bx, p.by, p.bh, p.ba, bx, by);
            nx[0] = ay[0] - ay[1]; ny[0] = ax[1] - ax[0];
            nx[1] = ay[1] - ay[2]; ny[1] = ax[2] - ax[1];
            nx[2] = by[0] - by[1]; ny[2] = bx[1] - bx[0];
            nx[3] = by[1] - by[2]; ny[3] = bx[2] - bx[1];
            for (int a = 0; a < 4; a++) begin
                lo1 = ax[0] * nx[a] + ay[0] * ny[a]; hi1 = lo1;
                lo2 = bx[0] * nx[a] + by[0] * ny[a]; hi2 = lo2;
                for (int i = 1; i < 4; i++) begin
                    v = ax[i] * nx[a] + ay[i] * ny[a];
                    if (v < lo1) lo1 = v;
                    if (v > hi1) hi1 = v;
                    v = bx[i] * nx[a] + by[i] * ny[a];
                    if (v < lo2) lo2 = v;
                    if (v > hi2) hi2 = v;
                end
                if (hi1 < lo2 || lo1 > hi2) return 0;
            end
            return 1;
        endfunction

        function void note_pair(t_square_pair p);
            pending = {pending, squares_overlap(p)};
        endfunction

        function void report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endfunction

        function void check_flag(logic got);
            bit want;
            if (pending.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
                return;
            end
            want = pending.pop_front();
            if (got !== want)
                report_mismatch($sformatf("overlapping got %b expected %b", got, want));
        endfunction
    endclass

    logic                      i_clk = 0;
    logic                      i_rst_n = 0;
    logic                      start = 0;
    logic                      busy;
    logic                      i_cfg_we = 0;
    logic [PPM_W-1:0]          i_cfg_data = '0;
    t_square_pair              drv = '{default: '0};
    logic                      o_valid;
    logic                      o_overlapping;
    t_overlap_scoreboard       sb;
    int                        cycles = 0;
    bit                        no_gaps = 0;

    oriented_square_overlap_test_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_first_center_x  (drv.ax),
        .i_first_center_y  (drv.ay),
        .i_first_half_side (drv.ah),
        .i_first_angle     (drv.aa),
        .i_second_center_x (drv.bx),
        .i_second_center_y (drv.by),
        .i_second_half_side(drv.bh),
        .i_second_angle    (drv.ba),
        .o_valid           (o_valid),
        .o_overlapping     (o_overlapping)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("oriented_square_overlap_test_unit regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_pair(drv);
        if (i_rst_n && i_cfg_we) sb.set_scale(i_cfg_data);
        if (i_rst_n && o_valid) sb.check_flag(o_overlapping);
    end

    task automatic send_pair(t_square_pair p);
        while (!no_gaps && $urandom_range(0, 99) < 21) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        drv   <= p;
        do @(posedge i_clk); while (busy);
    endtask

    // drain the pipe fully before touching the scale
    task automatic write_scale(logic [PPM_W-1:0] v);
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic t_square_pair random_pair();
        t_square_pair p;
        p.ax = COORD_W'($urandom); p.ay = COORD_W'($urandom);
        p.aa = ANG_W'($urandom); p.ba = ANG_W'($urandom);
        p.ah = ($urandom_range(0, 9) == 0) ? HALF_W'($urandom) : HALF_W'($urandom_range(0, 1023));
        p.bh = ($urandom_range(0, 9) == 0) ? HALF_W'($urandom) : HALF_W'($urandom_range(0, 1023));
        if ($urandom_range(0, 9) < 8) begin
            // neighbours: near contact, so both outcomes are common
            p.bx = p.ax + COORD_W'(int'($urandom_range(0, 1535)) - 768);
            p.by = p.ay + COORD_W'(int'($urandom_range(0, 1535)) - 768);
        end else begin
            p.bx = COORD_W'($urandom); p.by = COORD_W'($urandom);
        end
        return p;
    endfunction

    task automatic directed_pairs();
        t_square_pair p;
        p = '{default: '0};
        send_pair(p);                                   // both degenerate at origin
        p = '{16'sh7fff, 16'sh7fff, 13'h1fff, 16'sh7fff, 16'sh8000, 16'sh8000, 13'h1fff, 16'sh8000};
        send_pair(p);
        p = '{16'sh8000, 16'sh7fff, 13'h1fff, 16'sd25736, 16'sh8000, 16'sh7fff, 13'h0, -16'sd25736};
        send_pair(p);
        p = '{16'sd0, 16'sd0, 13'd256, 16'sd0, 16'sd512, 16'sd0, 13'd256, 16'sd0};
        send_pair(p);                                   // edges touching
        p = '{16'sd0, 16'sd0, 13'd256, 16'sd0, 16'sd513, 16'sd0, 13'd256, 16'sd0};
        send_pair(p);
        p = '{16'sd0, 16'sd0, 13'd256, 16'sd6434, 16'sd700, 16'sd0, 13'd256, 16'sd0};
        send_pair(p);                                   // diamond vs square
        p = '{16'sd100, -16'sd100, 13'd0, 16'sd0, 16'sd100, -16'sd100, 13'd300, 16'sd1000};
        send_pair(p);                                   // point inside square
        p = '{16'sd0, 16'sd0, 13'd0, 16'sd0, 16'sd3000, 16'sd0, 13'd0, 16'sd0};
        send_pair(p);                                   // two separate points
        p = '{16'sd0, 16'sd0, 13'd1000, 16'sd12868, 16'sd0, 16'sd0, 13'd1000, -16'sd12868};
        send_pair(p);
        p = '{16'sd40, 16'sd20, 13'd500, 16'sh7fff, -16'sd900, 16'sd30, 13'd400, 16'sh8000};
        send_pair(p);                                   // angles beyond pi
        p = '{16'sh7fff, 16'sh8000, 13'h1fff, 16'sd1, 16'sh8000, 16'sh7fff, 13'h1fff, -16'sd1};
        send_pair(p);
    endtask

    initial begin
        logic [PPM_W-1:0] scales[5];
        sb = new();
        sb.set_scale(PPM_RESET);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_pairs();
        scales = '{10'd0, 10'd1, 10'd1023, 10'($urandom_range(2, 1022)), 10'd50};
        foreach (scales[s]) begin
            write_scale(scales[s]);
            directed_pairs();
            for (int n = 0; n < 370; n++) begin
                no_gaps = (s == 2 && n >= 100 && n < 300);
                send_pair(random_pair());
            end
        end
        no_gaps = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("oriented_square_overlap_test_unit regression: pass");
        end else begin
            $display("oriented_square_overlap_test_unit regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/osot_pkg.sv
hw/rtl/osot_corners.sv
hw/rtl/osot_axis_lane.sv
hw/rtl/oriented_square_overlap_test_unit.sv
bench/tb_oriented_square_overlap_test_unit.sv
